@@ rtl/pfe_pkg.sv @@
// shared types and constants for the playfair digraph encrypt core
`default_nettype none

package pfe_pkg;

	localparam int unsigned SIDE       = 5;
	localparam int unsigned CELLS      = SIDE * SIDE;
	localparam int unsigned LETTER_W   = 5;
	localparam int unsigned POS_W      = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 50;
	localparam int unsigned LOW_W      = 50;
	localparam int unsigned MID_W      = 50;
	localparam int unsigned HIGH_W     = 25;

	localparam logic [LETTER_W-1:0] LETTER_I   = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J   = 5'd9;
	localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;
	localparam logic [POS_W-1:0]    POS_LAST   = 3'(SIDE - 1);

	localparam logic [CFG_IDX_W-1:0] REG_CELLS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_MID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_HIGH = 2'd2;

	typedef logic [CELLS-1:0][LETTER_W-1:0] square_t;

	typedef struct packed {
		logic [LETTER_W-1:0] first_letter;
		logic [LETTER_W-1:0] second_letter;
	} digraph_t;

	typedef struct packed {
		logic [LETTER_W-1:0] first_cipher;
		logic [LETTER_W-1:0] second_cipher;
		logic                letter_missing;
	} result_t;

	// position of one letter in the square
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} loc_t;

endpackage

`default_nettype wire

@@ rtl/pfe_locate_lane.sv @@
// one search lane: folds a letter and finds its row and column in the square
`default_nettype none

module pfe_locate_lane (
	input  wire  pfe_pkg::square_t                  square,
	input  wire  logic [pfe_pkg::LETTER_W-1:0]      letter,
	output       pfe_pkg::loc_t                     loc
);

	logic [pfe_pkg::LETTER_W-1:0] folded;

	assign folded = (letter == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : letter;

	// later cells override earlier ones, so the last match in row-major order wins
	always_comb begin
		loc = '0;
		if (folded <= pfe_pkg::LETTER_MAX) begin
			for (int r = 0; r < pfe_pkg::SIDE; r++) begin
				for (int c = 0; c < pfe_pkg::SIDE; c++) begin
					if (square[r * pfe_pkg::SIDE + c] == folded) begin
						loc.found = 1'b1;
						loc.row   = pfe_pkg::POS_W'(r);
						loc.col   = pfe_pkg::POS_W'(c);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/pfe_merge.sv @@
// merge stage: applies the column, row or rectangle rule to both lane positions, or flags a missing letter
`default_nettype none

module pfe_merge (
	input  wire  pfe_pkg::square_t square,
	input  wire  pfe_pkg::loc_t    loc_a,
	input  wire  pfe_pkg::loc_t    loc_b,
	output       pfe_pkg::result_t result
);

	localparam int unsigned IDX_W = $clog2(pfe_pkg::CELLS);

	logic [pfe_pkg::POS_W-1:0] row_x, col_x, row_y, col_y;
	logic [IDX_W-1:0]          idx_x, idx_y;

	function automatic logic [pfe_pkg::POS_W-1:0] wrap_next(
		input logic [pfe_pkg::POS_W-1:0] p
	);
		return (p == pfe_pkg::POS_LAST) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		if (loc_a.col == loc_b.col) begin
			row_x = wrap_next(loc_a.row);
			col_x = loc_a.col;
			row_y = wrap_next(loc_b.row);
			col_y = loc_b.col;
		end else if (loc_a.row == loc_b.row) begin
			row_x = loc_a.row;
			col_x = wrap_next(loc_a.col);
			row_y = loc_b.row;
			col_y = wrap_next(loc_b.col);
		end else begin
			// rectangle corners
			row_x = loc_a.row;
			col_x = loc_b.col;
			row_y = loc_b.row;
			col_y = loc_a.col;
		end
	end

	assign idx_x = IDX_W'(row_x * pfe_pkg::SIDE) + IDX_W'(col_x);
	assign idx_y = IDX_W'(row_y * pfe_pkg::SIDE) + IDX_W'(col_y);

	always_comb begin
		if (loc_a.found && loc_b.found) begin
			result.first_cipher   = square[idx_x];
			result.second_cipher  = square[idx_y];
			result.letter_missing = 1'b0;
		end else begin
			result.first_cipher   = '0;
			result.second_cipher  = '0;
			result.letter_missing = 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/playfair_digraph_encrypt_core.sv @@
// top level of the playfair digraph encrypt core: config registers, lanes, merge, output
//
// channel   ports                          transfer when
// input     start, busy, digraph           start high and busy low at a rising edge
// result    done, result                   done high, one cycle, always taken
// config    cfg_we, cfg_index, cfg_data    cfg_we high at a rising edge
//
// one digraph per cycle; after its transfer the result passes through
// the lane search register, then the merge into the output register
// busy is always low, the two-stage pipeline takes a digraph every cycle
// arst_n clears the square registers and the pipeline valid flags
// the receiver cannot stall, so no result is ever held back
`default_nettype none

module playfair_digraph_encrypt_core (
	input  wire  logic                                clk,
	input  wire  logic                                arst_n,
	input  wire  logic                                start,
	output       logic                                busy,
	input  wire  pfe_pkg::digraph_t                   digraph,
	output       logic                                done,
	output       pfe_pkg::result_t                    result,
	input  wire  logic                                cfg_we,
	input  wire  logic [pfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  logic [pfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [pfe_pkg::LOW_W-1:0]  cells_low_q;
	logic [pfe_pkg::MID_W-1:0]  cells_mid_q;
	logic [pfe_pkg::HIGH_W-1:0] cells_high_q;
	pfe_pkg::square_t           square;

	pfe_pkg::loc_t    loc_a, loc_b;
	pfe_pkg::loc_t    loc_a_s1, loc_b_s1;
	logic             valid_s1;
	pfe_pkg::result_t merged;
	logic             accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_low_q  <= '0;
			cells_mid_q  <= '0;
			cells_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfe_pkg::REG_CELLS_LOW:  cells_low_q  <= cfg_data[pfe_pkg::LOW_W-1:0];
				pfe_pkg::REG_CELLS_MID:  cells_mid_q  <= cfg_data[pfe_pkg::MID_W-1:0];
				pfe_pkg::REG_CELLS_HIGH: cells_high_q <= cfg_data[pfe_pkg::HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	// cell 0 sits in the low bits of the low register
	assign square = {cells_high_q, cells_mid_q, cells_low_q};

	pfe_locate_lane u_lane_a (
		.square (square),
		.letter (digraph.first_letter),
		.loc    (loc_a)
	);

	pfe_locate_lane u_lane_b (
		.square (square),
		.letter (digraph.second_letter),
		.loc    (loc_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		loc_a_s1 <= loc_a;
		loc_b_s1 <= loc_b;
	end

	pfe_merge u_merge (
		.square (square),
		.loc_a  (loc_a_s1),
		.loc_b  (loc_b_s1),
		.result (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		result <= merged;
	end

	a_accept_to_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted digraph did not reach the lane register");

	a_s1_to_done : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("lane result did not produce a result strobe");

	a_done_has_source : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a digraph in flight");

	a_missing_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && result.letter_missing |->
			result.first_cipher == '0 && result.second_cipher == '0)
		else $error("missing letter result carries nonzero cipher letters");

	a_found_not_missing : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && loc_a_s1.found && loc_b_s1.found |=> !result.letter_missing)
		else $error("both letters found but result flags a missing letter");

endmodule

`default_nettype wire
